### hw/rtl/grc_pkg.sv
`default_nettype none

package grc_pkg;

	// defaults for the top level parameters
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_EDGES_DEF    = 8192;

	// fixed field widths
	localparam int OP_W  = 2;
	localparam int IDX_W = 13;
	localparam int VAL_W = 14;
	localparam int OFS_W = 14;
	localparam int CNT_W = 11;

	// stream word widths, whole bytes
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// item opcodes
	localparam logic [OP_W-1:0] OP_ROW   = 2'd0;
	localparam logic [OP_W-1:0] OP_COL   = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
	localparam logic [OP_W-1:0] OP_START = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] target_index;
		logic [VAL_W-1:0] write_value;
	} grc_item_t;

	typedef struct packed {
		logic             ready;
		logic             result_valid;
		logic [CNT_W-1:0] reach_count;
	} grc_status_t;

endpackage

`default_nettype wire

### hw/rtl/grc_graph_store.sv
`default_nettype none

// CSR tables: row offsets and column entries, one read port each
module grc_graph_store #(
	parameter int MAX_VERTICES = grc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = grc_pkg::MAX_EDGES_DEF
) (
	input  wire logic                                 clk,
	input  wire grc_pkg::grc_item_t                   item,
	input  wire logic                                 item_valid,
	input  wire logic [$clog2(MAX_VERTICES+1)-1:0]    row_raddr,
	output logic      [grc_pkg::OFS_W-1:0]            row_rdata,
	input  wire logic [$clog2(MAX_EDGES)-1:0]         col_raddr,
	output logic      [$clog2(MAX_VERTICES):0]        col_rdata
);
	import grc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int RW = $clog2(MAX_VERTICES + 1);
	localparam int EW = $clog2(MAX_EDGES);

	logic [OFS_W-1:0] row_mem [MAX_VERTICES+1];
	logic [VW:0]      col_mem [MAX_EDGES];

	logic          row_we;
	logic          col_we;
	logic [VW:0]   col_wd;

	assign row_we = item_valid && (item.op == OP_ROW) &&
		(32'(item.target_index) <= 32'(MAX_VERTICES));
	assign col_we = item_valid && (item.op == OP_COL) &&
		(32'(item.target_index) < 32'(MAX_EDGES));

	// top bit flags a neighbour inside the vertex range
	assign col_wd = {(32'(item.write_value) < 32'(MAX_VERTICES)), VW'(item.write_value)};

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[RW'(item.target_index)] <= OFS_W'(item.write_value);
		end
		row_rdata <= row_mem[row_raddr];
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[EW'(item.target_index)] <= col_wd;
		end
		col_rdata <= col_mem[col_raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/grc_walk_core.sv
`default_nettype none

// walk sequencer: visited marks, explicit stack, tally
module grc_walk_core #(
	parameter int MAX_VERTICES = grc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = grc_pkg::MAX_EDGES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire grc_pkg::grc_item_t                   item,
	input  wire logic                                 item_valid,
	input  wire logic                                 out_free,
	output logic      [$clog2(MAX_VERTICES+1)-1:0]    row_raddr,
	input  wire logic [grc_pkg::OFS_W-1:0]            row_rdata,
	output logic      [$clog2(MAX_EDGES)-1:0]         col_raddr,
	input  wire logic [$clog2(MAX_VERTICES):0]        col_rdata,
	output grc_pkg::grc_status_t                      status
);
	import grc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int RW = $clog2(MAX_VERTICES + 1);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int DW = $clog2(MAX_VERTICES + 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_POP   = 4'd2;
	localparam logic [3:0] ST_FETCH = 4'd3;
	localparam logic [3:0] ST_ROWLO = 4'd4;
	localparam logic [3:0] ST_ROWHI = 4'd5;
	localparam logic [3:0] ST_SCAN  = 4'd6;
	localparam logic [3:0] ST_COL   = 4'd7;
	localparam logic [3:0] ST_MARK  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]       state_q, state_d;
	logic [VW-1:0]    clr_q, clr_d;
	logic [DW-1:0]    depth_q, depth_d;
	logic [CNT_W-1:0] tally_q, tally_d;
	logic [VW-1:0]    v_q, v_d;
	logic [OFS_W-1:0] lo_q, lo_d;
	logic [OFS_W-1:0] hi_q, hi_d;
	logic [OFS_W-1:0] j_q, j_d;
	logic [VW-1:0]    w_q, w_d;

	logic             mark_mem [MAX_VERTICES];
	logic             mark_rd_q;
	logic             mark_we, mark_wd;
	logic [VW-1:0]    mark_wa, mark_ra;

	logic [VW-1:0]    stack_mem [MAX_VERTICES];
	logic [VW-1:0]    stack_rd_q;
	logic             stack_we;
	logic [VW-1:0]    stack_wa, stack_wd, stack_ra;

	logic [DW-1:0]    depth_m1;
	logic             start_ok;
	logic             push_ok;

	assign depth_m1 = depth_q - DW'(1);
	assign start_ok = item_valid && (item.op == OP_START) &&
		(32'(item.target_index) < 32'(MAX_VERTICES));
	assign push_ok  = depth_q < DW'(MAX_VERTICES);

	assign col_raddr = EW'(j_q);

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		depth_d   = depth_q;
		tally_d   = tally_q;
		v_d       = v_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		j_d       = j_q;
		w_d       = w_q;
		mark_we   = 1'b0;
		mark_wa   = w_q;
		mark_wd   = 1'b1;
		mark_ra   = VW'(col_rdata);
		stack_we  = 1'b0;
		stack_wa  = depth_q[VW-1:0];
		stack_wd  = w_q;
		stack_ra  = depth_m1[VW-1:0];
		row_raddr = RW'(stack_rd_q);
		status.ready        = 1'b0;
		status.result_valid = 1'b0;
		status.reach_count  = tally_q;

		case (state_q)
			ST_CLEAR: begin
				mark_we = 1'b1;
				mark_wa = clr_q;
				mark_wd = 1'b0;
				clr_d   = clr_q + VW'(1);
				if (clr_q == VW'(MAX_VERTICES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				status.ready = 1'b1;
				if (item_valid && (item.op == OP_MARK) &&
					(32'(item.target_index) < 32'(MAX_VERTICES))) begin
					mark_we = 1'b1;
					mark_wa = VW'(item.target_index);
					mark_wd = item.write_value[0];
				end
				if (start_ok) begin
					// start vertex is counted even if already marked
					mark_we  = 1'b1;
					mark_wa  = VW'(item.target_index);
					mark_wd  = 1'b1;
					stack_we = 1'b1;
					stack_wa = '0;
					stack_wd = VW'(item.target_index);
					depth_d  = DW'(1);
					tally_d  = CNT_W'(1);
					state_d  = ST_POP;
				end
			end
			ST_POP: begin
				if (depth_q == '0) begin
					state_d = ST_DONE;
				end else begin
					depth_d = depth_m1;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				// stack word is out: read the row start
				v_d       = stack_rd_q;
				row_raddr = RW'(stack_rd_q);
				state_d   = ST_ROWLO;
			end
			ST_ROWLO: begin
				lo_d      = row_rdata;
				row_raddr = RW'(v_q) + RW'(1);
				state_d   = ST_ROWHI;
			end
			ST_ROWHI: begin
				if (32'(row_rdata) > 32'(MAX_EDGES)) begin
					hi_d = OFS_W'(MAX_EDGES);
				end else begin
					hi_d = row_rdata;
				end
				j_d     = lo_q;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (j_q < hi_q) begin
					j_d     = j_q + OFS_W'(1);
					state_d = ST_COL;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_COL: begin
				if (col_rdata[VW]) begin
					w_d     = VW'(col_rdata);
					state_d = ST_MARK;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_MARK: begin
				if (!mark_rd_q) begin
					mark_we = 1'b1;
					tally_d = tally_q + CNT_W'(1);
					if (push_ok) begin
						stack_we = 1'b1;
						depth_d  = depth_q + DW'(1);
					end
				end
				state_d = ST_SCAN;
			end
			ST_DONE: begin
				if (out_free) begin
					status.result_valid = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			depth_q <= '0;
			tally_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			depth_q <= depth_d;
			tally_q <= tally_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q  <= v_d;
		lo_q <= lo_d;
		hi_q <= hi_d;
		j_q  <= j_d;
		w_q  <= w_d;
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		mark_rd_q <= mark_mem[mark_ra];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_wa] <= stack_wd;
		end
		stack_rd_q <= stack_mem[stack_ra];
	end

endmodule

`default_nettype wire

### hw/rtl/graph_reach_counter.sv
`default_nettype none

// Depth-first reachability counter over a graph in compressed sparse row form.
// Input words load the row offset table (op 0), the column table (op 1) and
// the visited marks (op 2); a start word (op 3) walks from the given vertex
// and returns one output word holding the number of vertices it newly
// reached, the start vertex always included. Marks stay set after a walk, so
// marking vertices beforehand excludes them. Loads with an index beyond
// their table are dropped, as is a start beyond the vertex range (no output).
// After reset the mark memory is swept to zero with s_axis_tready low;
// load words are then accepted back to back while the block is idle. A
// walk hands its count to the output register when it ends; every table
// sits in a memory with one registered read port, each popped vertex costs
// a pop, a stack read, two row reads and the final scan test, and each edge
// costs a scan test and a column read, followed by a mark read when it
// leads into range. Loads are accepted while a finished count waits on
// m_axis.
module graph_reach_counter #(
	parameter int MAX_VERTICES = grc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = grc_pkg::MAX_EDGES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] op, [14:2] target_index, [28:15] write_value, rest zero
	input  wire logic [grc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [10:0] reach_count, rest zero
	output logic      [grc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import grc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int RW = $clog2(MAX_VERTICES + 1);
	localparam int EW = $clog2(MAX_EDGES);

	grc_item_t        item;
	grc_status_t      status;
	logic             accept;
	logic             out_free;
	logic [RW-1:0]    row_raddr;
	logic [OFS_W-1:0] row_rdata;
	logic [EW-1:0]    col_raddr;
	logic [VW:0]      col_rdata;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;

	// unpack the input word
	assign item.op           = s_axis_tdata[OP_W-1:0];
	assign item.target_index = s_axis_tdata[OP_W+IDX_W-1:OP_W];
	assign item.write_value  = s_axis_tdata[OP_W+IDX_W+VAL_W-1:OP_W+IDX_W];

	assign s_axis_tready = status.ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	grc_graph_store #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_store (
		.clk        (clk),
		.item       (item),
		.item_valid (accept),
		.row_raddr  (row_raddr),
		.row_rdata  (row_rdata),
		.col_raddr  (col_raddr),
		.col_rdata  (col_rdata)
	);

	grc_walk_core #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (accept),
		.out_free   (out_free),
		.row_raddr  (row_raddr),
		.row_rdata  (row_rdata),
		.col_raddr  (col_raddr),
		.col_rdata  (col_rdata),
		.status     (status)
	);

	// output register: holds the count until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.result_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.result_valid) begin
			count_q <= status.reach_count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - CNT_W){1'b0}}, count_q};

endmodule

`default_nettype wire

### bench/reach_count_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of graph_reach_counter. Keeps its own copy of
// the offset, column and mark tables, walks the graph for every accepted
// start word inside the vertex range and compares each output word with the oldest predicted count.
module reach_count_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [grc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [grc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	output int                               fail_count,
	output int                               pending
);

	import grc_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;
	localparam int NE = MAX_EDGES_DEF;

	logic [OFS_W-1:0] row_ofs [0:NV];
	logic [VAL_W-1:0] col_ent [0:NE-1];
	bit               visited [0:NV-1];
	logic [CNT_W-1:0] count_q [$];

	// depth-first walk; marks stay set afterwards
	function automatic logic [CNT_W-1:0] walk_reach(input int root);
		int stack [NV];
		int depth;
		int tally;
		int v, lo, hi, w, j;
		tally = 1;
		depth = 1;
		stack[0] = root;
		visited[root] = 1'b1;
		while (depth > 0) begin
			depth--;
			v = stack[depth];
			lo = row_ofs[v];
			hi = row_ofs[v + 1];
			if (hi > NE)
				hi = NE;
			for (j = lo; j < hi; j++) begin
				w = col_ent[j];
				if (w < NV && !visited[w]) begin
					visited[w] = 1'b1;
					tally++;
					if (depth < NV) begin
						stack[depth] = w;
						depth++;
					end
				end
			end
		end
		return CNT_W'(tally);
	endfunction

	initial begin
		for (int i = 0; i <= NV; i++)
			row_ofs[i] = '0;
		for (int i = 0; i < NE; i++)
			col_ent[i] = '0;
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < NV; i++)
				visited[i] = 1'b0;
			count_q.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (count_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: output word %0d with no walk outstanding",
							$time, m_axis_tdata);
				end else begin
					want = count_q.pop_front();
					if (m_axis_tdata !== M_TDATA_W'(want)) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: reach_count expected %0d, got %0d",
								$time, want, m_axis_tdata);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				op  = s_axis_tdata[OP_W-1:0];
				idx = s_axis_tdata[OP_W +: IDX_W];
				val = s_axis_tdata[OP_W+IDX_W +: VAL_W];
				case (op)
					OP_ROW: begin
						if (idx <= NV)
							row_ofs[idx] = val;
					end
					OP_COL: begin
						if (idx < NE)
							col_ent[idx] = val;
					end
					OP_MARK: begin
						if (idx < NV)
							visited[idx] = val[0];
					end
					default: begin
						// start beyond the vertex range gives no word
						if (idx < NV)
							count_q.push_back(walk_reach(idx));
					end
				endcase
			end
		end
		pending = count_q.size();
	end

endmodule

### bench/tb_graph_reach_counter.sv
`timescale 1ns / 100ps

module tb_graph_reach_counter;

	import grc_pkg::*;

	localparam int NV          = MAX_VERTICES_DEF;
	localparam int NE          = MAX_EDGES_DEF;
	localparam int LOAD_WORDS  = 1950;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_LIMIT = 200_000;
	localparam int VAL_MAX     = 2**VAL_W - 1;
	localparam int IDX_MAX     = 2**IDX_W - 1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [1:0] op, [14:2] target_index, [28:15] write_value, rest zero
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [10:0] reach_count, rest zero
	logic [M_TDATA_W-1:0]   m_axis_tdata;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int live_words = 0;

	// current graph window: vertices [win_base, win_base+win_size),
	// columns [edge_base, edge_base+edge_cnt)
	int win_base, win_size, edge_base, edge_cnt;
	bit calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	graph_reach_counter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	reach_count_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// valid is only dropped when a gap follows, so it never toggles in one step
	task automatic send_word(input logic [OP_W-1:0] op, input int idx, input int val,
			input bit counts);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, VAL_W'(val), IDX_W'(idx), op};
		do @(posedge clk); while (!s_axis_tready);
		if (counts)
			live_words++;
	endtask

	// mostly in-window neighbours, some beyond the vertex range (skipped)
	function automatic int pick_neighbor();
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(NV, VAL_MAX);
		return win_base + $urandom_range(0, win_size - 1);
	endfunction

	// any offset inside the written columns keeps every scan on written slots;
	// past the edge table only when the columns run up to its end
	function automatic int pick_offset();
		if (edge_base + edge_cnt == NE && $urandom_range(0, 3) == 0)
			return $urandom_range(edge_base, VAL_MAX);
		return $urandom_range(edge_base, edge_base + edge_cnt);
	endfunction

	task automatic clear_marks();
		for (int j = 0; j < win_size; j++)
			send_word(OP_MARK, win_base + j, $urandom_range(0, VAL_MAX) & ~1, 1'b1);
	endtask

	task automatic run_episode();
		int j, k, v, ofs, steps;
		win_size  = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 96)
			: $urandom_range(2, 12);
		win_base  = ($urandom_range(0, 7) == 0) ? NV - win_size
			: $urandom_range(0, NV - win_size);
		edge_cnt  = $urandom_range(win_size, 3 * win_size);
		edge_base = ($urandom_range(0, 7) == 0) ? NE - edge_cnt
			: $urandom_range(0, NE - edge_cnt);
		calm = ($urandom_range(0, 5) == 0);

		for (j = 0; j < edge_cnt; j++)
			send_word(OP_COL, edge_base + j, pick_neighbor(), 1'b1);
		// mostly ascending offsets, now and then a random (maybe reversed) one
		ofs = edge_base;
		for (j = 0; j <= win_size; j++) begin
			if ($urandom_range(0, 7) == 0)
				send_word(OP_ROW, win_base + j, pick_offset(), 1'b1);
			else begin
				send_word(OP_ROW, win_base + j, ofs, 1'b1);
				ofs += $urandom_range(0, 2 * edge_cnt / win_size);
				if (ofs > edge_base + edge_cnt)
					ofs = edge_base + edge_cnt;
			end
		end
		if ($urandom_range(0, 1) == 0)
			clear_marks();

		steps = $urandom_range(4, 10);
		for (k = 0; k < steps; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_word(OP_START, win_base + $urandom_range(0, win_size - 1),
					$urandom_range(0, VAL_MAX), 1'b1);
				4: clear_marks();
				5: send_word(OP_MARK, win_base + $urandom_range(0, win_size - 1),
					$urandom_range(0, VAL_MAX), 1'b1);
				6: begin
					// marks outside the window are harmless, never popped
					v = $urandom_range(0, IDX_MAX);
					send_word(OP_MARK, v, $urandom_range(0, VAL_MAX), v < NV);
				end
				7: send_word(OP_COL, edge_base + $urandom_range(0, edge_cnt - 1),
					pick_neighbor(), 1'b1);
				8: send_word(OP_ROW, win_base + $urandom_range(0, win_size),
					pick_offset(), 1'b1);
				default: begin
					// out-of-range words the block drops
					case ($urandom_range(0, 2))
						0: send_word(OP_ROW, $urandom_range(NV + 1, IDX_MAX),
							$urandom_range(0, VAL_MAX), 1'b0);
						1: send_word(OP_MARK, $urandom_range(NV, IDX_MAX),
							$urandom_range(0, VAL_MAX), 1'b0);
						default: send_word(OP_START, $urandom_range(NV, IDX_MAX),
							$urandom_range(0, VAL_MAX), 1'b0);
					endcase
				end
			endcase
		end
	endtask

	// output side: random ready stall before each word, none in calm stretches
	initial begin
		int stall;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int drain;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// small graph at the top of both tables:
		// 1020 -> 1021, 1022; 1021 -> out-of-range; 1022 none; 1023 -> itself,
		// its row end past the edge table
		send_word(OP_START, IDX_MAX, 0, 1'b0);
		send_word(OP_ROW, IDX_MAX, 0, 1'b0);
		send_word(OP_MARK, IDX_MAX, 1, 1'b0);
		send_word(OP_COL, NE - 4, NV - 3, 1'b1);
		send_word(OP_COL, NE - 3, NV - 2, 1'b1);
		send_word(OP_COL, NE - 2, VAL_MAX, 1'b1);
		send_word(OP_COL, NE - 1, NV - 1, 1'b1);
		send_word(OP_ROW, NV - 4, NE - 4, 1'b1);
		send_word(OP_ROW, NV - 3, NE - 2, 1'b1);
		send_word(OP_ROW, NV - 2, NE - 1, 1'b1);
		send_word(OP_ROW, NV - 1, NE - 1, 1'b1);
		send_word(OP_ROW, NV, VAL_MAX, 1'b1);
		// premarked 1021 is excluded
		send_word(OP_MARK, NV - 3, VAL_MAX, 1'b1);
		send_word(OP_START, NV - 4, VAL_MAX, 1'b1);
		// start already marked still counts itself
		send_word(OP_START, NV - 4, 0, 1'b1);
		// only bit 0 of the mark value matters
		send_word(OP_MARK, NV - 4, VAL_MAX - 1, 1'b1);
		send_word(OP_MARK, NV - 3, VAL_MAX - 1, 1'b1);
		send_word(OP_MARK, NV - 2, VAL_MAX - 1, 1'b1);
		send_word(OP_START, NV - 4, 0, 1'b1);
		send_word(OP_START, NV - 1, 0, 1'b1);
		// reversed bounds on vertex 0
		send_word(OP_ROW, 0, VAL_MAX, 1'b1);
		send_word(OP_ROW, 1, 0, 1'b1);
		send_word(OP_START, 0, 0, 1'b1);

		while (live_words < LOAD_WORDS)
			run_episode();
		s_axis_tvalid <= 1'b0;

		drain = 0;
		do begin
			@(posedge clk);
			drain++;
		end while (pending != 0 && drain < DRAIN_LIMIT);
		repeat (50) @(posedge clk);
		if (pending != 0)
			$display("%0d walk counts never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
